// ----- sv/rfss_pkg.sv -----
package rfss_pkg;

  localparam int BYTE_W           = 8;
  localparam int CFG_DATA_W       = 64;
  localparam int NEEDLE_LEN_W     = 5;
  // needle bytes held by the two needle registers
  localparam int NEEDLE_REG_BYTES = 16;
  localparam int NEEDLE_REG_W     = NEEDLE_REG_BYTES * BYTE_W;
  // width that holds any needle length, clamped or not (max 31)
  localparam int LEN_EXT_W        = 7;
  localparam logic [BYTE_W-1:0] ASCII_TOP = 8'd128;

  typedef enum logic [2:0] {
    REG_NEEDLE_LOW   = 3'd0,
    REG_NEEDLE_HIGH  = 3'd1,
    REG_NEEDLE_LEN   = 3'd2,
    REG_FOLD         = 3'd3,
    REG_START_LINE   = 3'd4,
    REG_START_COLUMN = 3'd5,
    REG_END_LINE     = 3'd6,
    REG_END_COLUMN   = 3'd7
  } cfg_reg_t;

  function automatic logic [BYTE_W-1:0] upper_ascii(input logic [BYTE_W-1:0] c);
    if (c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic bytes_equal(input logic fold, input logic [BYTE_W-1:0] a,
                                       input logic [BYTE_W-1:0] b);
    if (fold && a < ASCII_TOP && b < ASCII_TOP) begin
      return upper_ascii(a) == upper_ascii(b);
    end
    return a == b;
  endfunction

endpackage

// ----- sv/ranged_folding_substring_search_core.sv -----
// Case-insensitive (optional) substring search over a line-structured byte stream.
// Each input item is one text byte (s_tuser = 0) or a line break (s_tuser = 1);
// s_tlast on a line break ends the document. The block reports the first match of
// the configured needle (1..NEEDLE_MAX bytes) that lies wholly inside one line and
// within the configured start/end position, as one output item with m_tuser = 1.
// If the document ends without a match, the final line break yields one item with
// m_tuser = 0 and zero tdata. After the final line break the line/column counters
// and search state return to reset; configuration is kept. Throughput is one item
// per clock while not stalled: an item goes through an input register and then the
// window compare, which checks all needle positions in parallel, into the output
// register, which drives m_tvalid. The input stalls only while both registers hold
// items and the receiver holds off. Line and column counters saturate.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
module ranged_folding_substring_search_core
  import rfss_pkg::*;
#(
  parameter int NEEDLE_MAX  = 16,
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [BYTE_W-1:0]                        s_tdata,   // text_byte
  input  logic                                     s_tuser,   // is_line_break
  input  logic                                     s_tlast,   // is_last
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((LINE_BITS+COLUMN_BITS+7)/8)*8-1:0] m_tdata, // match_line, match_column
  output logic                                     m_tuser,   // found
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [2:0]                               cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_data
);

  localparam int OUT_W = ((LINE_BITS + COLUMN_BITS + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - LINE_BITS - COLUMN_BITS;
  localparam int FILL_W = $clog2(NEEDLE_MAX + 1);
  localparam int IDX_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int CW = (COLUMN_BITS + 1 > LEN_EXT_W) ? COLUMN_BITS + 1 : LEN_EXT_W;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  // configuration
  logic [NEEDLE_REG_W-1:0]   needle;
  logic [NEEDLE_LEN_W-1:0]   needle_len;
  logic                      fold_enable;
  logic [LINE_BITS-1:0]      first_line;
  logic [COLUMN_BITS-1:0]    first_col;
  logic [LINE_BITS-1:0]      last_line;
  logic [COLUMN_BITS-1:0]    last_col;

  // input register
  logic                      in_valid;
  logic [BYTE_W-1:0]         in_byte;
  logic                      in_brk;
  logic                      in_last;

  // search state
  logic [BYTE_W-1:0]         window [NEEDLE_MAX];
  logic [BYTE_W-1:0]         window_next [NEEDLE_MAX];
  logic [FILL_W-1:0]         fill;
  logic [FILL_W-1:0]         fill_next;
  logic [LINE_BITS-1:0]      line_counter;
  logic [COLUMN_BITS-1:0]    column_counter;
  logic                      reported;

  // output register
  logic                      out_valid;
  logic                      out_found;
  logic [LINE_BITS-1:0]      out_line;
  logic [COLUMN_BITS-1:0]    out_column;

  logic                      out_free;
  logic                      step;
  logic [LEN_EXT_W-1:0]      len_ext;
  logic [LEN_EXT_W-1:0]      len_eff;
  logic [CW-1:0]             len_cw;
  logic [CW-1:0]             col1;
  logic [COLUMN_BITS-1:0]    match_start;
  logic                      range_ok;
  logic                      cand;
  logic                      hit;
  logic                      emit;
  logic [LEN_EXT_W-1:0]      idx;
  logic [BYTE_W-1:0]         nb;

  assign out_free  = !out_valid || m_tready;
  assign step      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = {{PAD_W{1'b0}}, out_column, out_line};

  always_comb begin
    window_next[0] = in_byte;
    for (int i = 1; i < NEEDLE_MAX; i++) begin
      window_next[i] = window[i-1];
    end
    fill_next = (fill < FILL_W'(NEEDLE_MAX)) ? fill + 1'b1 : fill;

    len_ext = LEN_EXT_W'(needle_len);
    len_eff = (len_ext > LEN_EXT_W'(NEEDLE_MAX)) ? LEN_EXT_W'(NEEDLE_MAX) : len_ext;
    len_cw  = CW'(len_eff);
    col1    = CW'(column_counter) + 1'b1;
    match_start = COLUMN_BITS'(col1 - len_cw);

    range_ok = (first_line < last_line) ||
               (first_line == last_line && first_col < last_col);

    cand = !reported && len_eff != '0 && CW'(fill_next) >= len_cw && col1 >= len_cw &&
           range_ok && line_counter >= first_line && line_counter <= last_line &&
           !(line_counter == first_line && match_start < first_col) &&
           !(line_counter == last_line && col1 > CW'(last_col));

    // needle byte i lines up with the byte that arrived len-1-i items ago
    hit = 1'b1;
    idx = '0;
    nb  = '0;
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      if (LEN_EXT_W'(i) < len_eff) begin
        idx = len_eff - 1'b1 - LEN_EXT_W'(i);
        nb  = (i < NEEDLE_REG_BYTES) ? needle[(i % NEEDLE_REG_BYTES)*BYTE_W +: BYTE_W] : '0;
        if (!bytes_equal(fold_enable, window_next[idx[IDX_W-1:0]], nb)) begin
          hit = 1'b0;
        end
      end
    end

    emit = step && (in_brk ? (in_last && !reported) : (cand && hit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle         <= '0;
      needle_len     <= NEEDLE_LEN_W'(1);
      fold_enable    <= 1'b0;
      first_line     <= '0;
      first_col      <= '0;
      last_line      <= LINE_MAX;
      last_col       <= COL_MAX;
      in_valid       <= 1'b0;
      fill           <= '0;
      line_counter   <= '0;
      column_counter <= '0;
      reported       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_NEEDLE_LOW:   needle[CFG_DATA_W-1:0] <= cfg_data;
          REG_NEEDLE_HIGH:  needle[NEEDLE_REG_W-1:CFG_DATA_W] <= cfg_data;
          REG_NEEDLE_LEN:   needle_len <= cfg_data[NEEDLE_LEN_W-1:0];
          REG_FOLD:         fold_enable <= cfg_data[0];
          REG_START_LINE:   first_line <= cfg_data[LINE_BITS-1:0];
          REG_START_COLUMN: first_col <= cfg_data[COLUMN_BITS-1:0];
          REG_END_LINE:     last_line <= cfg_data[LINE_BITS-1:0];
          REG_END_COLUMN:   last_col <= cfg_data[COLUMN_BITS-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
        in_byte  <= s_tdata;
        in_brk   <= s_tuser;
        in_last  <= s_tlast;
      end else if (step) begin
        in_valid <= 1'b0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      if (step) begin
        if (in_brk) begin
          fill           <= '0;
          column_counter <= '0;
          if (in_last) begin
            line_counter <= '0;
            reported     <= 1'b0;
            if (!reported) begin
              out_found  <= 1'b0;
              out_line   <= '0;
              out_column <= '0;
            end
          end else if (line_counter != LINE_MAX) begin
            line_counter <= line_counter + 1'b1;
          end
        end else begin
          window <= window_next;
          fill   <= fill_next;
          if (column_counter != COL_MAX) begin
            column_counter <= column_counter + 1'b1;
          end
          if (cand && hit) begin
            reported   <= 1'b1;
            out_found  <= 1'b1;
            out_line   <= line_counter;
            out_column <= match_start;
          end
        end
      end
    end
  end

endmodule

// ----- sv/rfss_checker.sv -----
module rfss_checker #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser
);

  // a not-found item carries no position
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found item with nonzero position");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  // input side only stalls on output backpressure
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled with output ready");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output item valid after reset");

endmodule

bind ranged_folding_substring_search_core rfss_checker #(.OUT_W(OUT_W)) u_rfss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rfss_pkg::*;

  localparam int M_W         = ((16 + 12 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    bit        found;
    bit [15:0] line_idx;
    bit [11:0] col_idx;
  } search_hit_t;

  typedef struct {
    cfg_reg_t  idx;
    bit [63:0] val;
  } reg_write_t;

  // Tracks the document position and the window, and queues the hit (or the
  // not-found item) that each accepted item should produce.
  class match_predictor;
    bit [63:0]   needle_lo, needle_hi;
    bit [4:0]    needle_len;
    bit          fold;
    bit [15:0]   first_line, last_line;
    bit [11:0]   first_col, end_col;
    bit [7:0]    recent[16];
    int          fill, line_no, col_no;
    bit          reported;
    search_hit_t expected_hits[$];
    int          errors;

    function new();
      needle_len = 5'd1;
      last_line  = '1;
      end_col    = '1;
      clear_document();
    endfunction

    function void clear_document();
      recent   = '{default: 8'h00};
      fill     = 0;
      line_no  = 0;
      col_no   = 0;
      reported = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [63:0] v);
      case (idx)
        REG_NEEDLE_LOW:   needle_lo  = v;
        REG_NEEDLE_HIGH:  needle_hi  = v;
        REG_NEEDLE_LEN:   needle_len = v[4:0];
        REG_FOLD:         fold       = v[0];
        REG_START_LINE:   first_line = v[15:0];
        REG_START_COLUMN: first_col  = v[11:0];
        REG_END_LINE:     last_line  = v[15:0];
        REG_END_COLUMN:   end_col    = v[11:0];
        default: ;
      endcase
    endfunction

    function int eff_len();
      return (needle_len > 16) ? 16 : int'(needle_len);
    endfunction

    function bit [7:0] needle_byte(int i);
      if (i < 8) return needle_lo[8*i +: 8];
      if (i < 16) return needle_hi[8*(i-8) +: 8];
      return 8'h00;
    endfunction

    function bit [7:0] upcase(bit [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    endfunction

    function bit same_byte(bit [7:0] a, bit [7:0] b);
      if (fold && a < 8'd128 && b < 8'd128) return upcase(a) == upcase(b);
      return a == b;
    endfunction

    function void take_item(bit [7:0] b, bit brk, bit last);
      int col, len, start;
      bit range_ok;
      if (brk) begin
        if (last) begin
          if (!reported) expected_hits.push_back('{1'b0, 16'd0, 12'd0});
          clear_document();
        end else begin
          recent = '{default: 8'h00};
          fill   = 0;
          col_no = 0;
          if (line_no < 65535) line_no++;
        end
        return;
      end
      for (int i = 15; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (fill < 16) fill++;
      col = col_no;
      if (col_no < 4095) col_no++;
      len = eff_len();
      if (reported || len == 0 || fill < len || col + 1 < len) return;
      range_ok = first_line < last_line ||
                 (first_line == last_line && first_col < end_col);
      if (!range_ok || line_no < first_line || line_no > last_line) return;
      start = col + 1 - len;
      if (line_no == first_line && start < first_col) return;
      if (line_no == last_line && col + 1 > end_col) return;
      // window index 0 is the newest byte, so needle byte 0 sits at len-1
      for (int i = 0; i < len; i++) begin
        if (!same_byte(recent[len-1-i], needle_byte(i))) return;
      end
      reported = 1'b1;
      expected_hits.push_back('{1'b1, line_no[15:0], start[11:0]});
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_hit(bit found, bit [15:0] line_idx, bit [11:0] col_idx);
      search_hit_t want;
      if (expected_hits.size() == 0) begin
        report($sformatf("unexpected item found=%0d line=%0d col=%0d",
                         found, line_idx, col_idx));
        return;
      end
      want = expected_hits.pop_front();
      if (found != want.found)
        report($sformatf("found %0d, want %0d", found, want.found));
      if (line_idx != want.line_idx)
        report($sformatf("match_line %0d, want %0d", line_idx, want.line_idx));
      if (col_idx != want.col_idx)
        report($sformatf("match_column %0d, want %0d", col_idx, want.col_idx));
    endtask
  endclass

  logic           clk;
  logic           rst       = 1'b1;
  logic           s_tvalid  = 1'b0;
  logic           s_tready;
  logic [7:0]     s_tdata   = '0;
  logic           s_tuser   = 1'b0;
  logic           s_tlast   = 1'b0;
  logic           m_tvalid;
  logic           m_tready  = 1'b0;
  logic [M_W-1:0] m_tdata;
  logic           m_tuser;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [63:0]    cfg_data  = '0;

  match_predictor matcher = new();
  reg_write_t     reg_writes[$];
  bit             quiet;
  bit             hold_req;
  int             gap_pct;
  int             items_sent;

  ranged_folding_substring_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ranged_folding_substring_search_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      matcher.check_hit(m_tuser, m_tdata[15:0], m_tdata[27:16]);
  end

  // receiver: random stalls, one long hold on request, none when quiet
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task send_item(bit [7:0] b, bit brk, bit last);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= brk;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    matcher.take_item(b, brk, last);
    items_sent++;
  endtask

  function void queue_reg(cfg_reg_t idx, bit [63:0] v);
    reg_writes.push_back('{idx, v});
  endfunction

  task write_regs();
    foreach (reg_writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_writes[i].idx;
      cfg_data  <= reg_writes[i].val;
      do @(posedge clk); while (!cfg_ready);
      matcher.write_reg(reg_writes[i].idx, reg_writes[i].val);
    end
    cfg_valid <= 1'b0;
    reg_writes = {};
  endtask

  // A line break may still be in flight after the last result, so give the
  // two-stage pipeline some slack before touching the registers.
  task wait_idle();
    s_tvalid <= 1'b0;
    while (matcher.expected_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function bit is_letter(bit [7:0] b);
    bit [7:0] u;
    u = b & 8'hDF;
    return u >= 8'h41 && u <= 8'h5A;
  endfunction

  function bit [7:0] variant(bit [7:0] b);
    int r;
    r = $urandom_range(0, 11);
    if (is_letter(b) && r < 3) return b ^ 8'h20;
    if (r == 3) return b ^ 8'h80;
    return b;
  endfunction

  function bit [7:0] letter();
    return (8'h41 + 8'($urandom_range(0, 25))) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
  endfunction

  function bit [7:0] filler_byte(int nlen);
    case ($urandom_range(0, 3))
      0, 1: begin
        if (nlen > 0) return variant(matcher.needle_byte($urandom_range(0, nlen - 1)));
        return 8'($urandom_range(0, 255));
      end
      2: return 8'($urandom_range(0, 255));
      default: return letter();
    endcase
  endfunction

  function bit [7:0] pick_needle_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return letter();
    if (r == 7) return 8'($urandom_range(0, 255));
    if (r == 8) return 8'($urandom_range(128, 255));
    return 8'h00;
  endfunction

  function bit [63:0] with_junk(bit [63:0] v, int w);
    bit [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return v | (r << w);
    return v;
  endfunction

  function int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 4);
    if (r == 7) return $urandom_range(5, 16);
    if (r == 8) return $urandom_range(17, 31);
    return 0;
  endfunction

  task random_settings();
    bit [63:0] lo, hi;
    bit [15:0] sl, el;
    bit [11:0] sc, ec;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pick_needle_byte();
      hi[8*i +: 8] = pick_needle_byte();
    end
    if ($urandom_range(0, 3) != 0) queue_reg(REG_NEEDLE_LOW, lo);
    if ($urandom_range(0, 3) != 0) queue_reg(REG_NEEDLE_HIGH, hi);
    if ($urandom_range(0, 3) != 0)
      queue_reg(REG_NEEDLE_LEN, with_junk(64'(pick_length()), 5));
    if ($urandom_range(0, 2) != 0)
      queue_reg(REG_FOLD, with_junk(64'($urandom_range(0, 1)), 1));
    case ($urandom_range(0, 6))
      0: begin sl = '0; sc = '0; el = '1; ec = '1; end
      1: begin
        sl = 16'($urandom_range(0, 2));
        sc = 12'($urandom_range(0, 10));
        el = sl + 16'($urandom_range(0, 2));
        ec = 12'($urandom_range(0, 40));
      end
      2: begin  // inverted
        sl = 16'($urandom_range(2, 3));
        el = 16'($urandom_range(0, 1));
        sc = 12'($urandom_range(0, 4095));
        ec = 12'($urandom_range(0, 4095));
      end
      3: begin  // empty
        sl = 16'($urandom_range(0, 3));
        el = sl;
        sc = 12'($urandom_range(0, 20));
        ec = sc;
      end
      4: begin
        sl = 16'($urandom_range(0, 1));
        sc = 12'($urandom_range(0, 30));
        el = '1;
        ec = 12'($urandom_range(0, 4095));
      end
      5: begin
        sl = '0;
        sc = '0;
        el = 16'($urandom_range(0, 3));
        ec = 12'($urandom_range(0, 40));
      end
      default: begin sl = '0; sc = '1; el = '1; ec = '0; end
    endcase
    queue_reg(REG_START_LINE, with_junk(64'(sl), 16));
    queue_reg(REG_START_COLUMN, with_junk(64'(sc), 12));
    queue_reg(REG_END_LINE, with_junk(64'(el), 16));
    queue_reg(REG_END_COLUMN, with_junk(64'(ec), 12));
    write_regs();
  endtask

  // Lines of random filler, most of them carrying a copy of the needle
  // (exact or slightly damaged) at a random spot.
  task send_document(int n_lines, int max_len);
    bit [7:0] text[$];
    int len, pos, nlen;
    bit exact;
    nlen = matcher.eff_len();
    for (int ln = 0; ln < n_lines; ln++) begin
      text = {};
      len  = $urandom_range(0, max_len);
      for (int k = 0; k < len; k++) text.push_back(filler_byte(nlen));
      if (nlen > 0 && $urandom_range(0, 2) != 0) begin
        pos   = $urandom_range(0, len);
        exact = 1'($urandom_range(0, 1));
        for (int k = 0; k < nlen; k++)
          text.insert(pos + k, exact ? matcher.needle_byte(k)
                                     : variant(matcher.needle_byte(k)));
      end
      foreach (text[k]) send_item(text[k], 1'b0, $urandom_range(0, 19) == 0);
      send_item(8'($urandom_range(0, 255)), 1'b1, ln == n_lines - 1);
    end
  endtask

  initial begin
    int base, phase;
    bit [63:0] lo, hi;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_idle();

    // reset needle is a single zero byte
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // needle "Ab" + 0xE1, folded, only line 1 columns 1..4
    queue_reg(REG_NEEDLE_LOW, 64'hFFFF_FFFF_FFE1_6241);
    queue_reg(REG_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_reg(REG_NEEDLE_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
    queue_reg(REG_FOLD, 64'h1);
    queue_reg(REG_START_LINE, 64'd1);
    queue_reg(REG_START_COLUMN, 64'd1);
    queue_reg(REG_END_LINE, 64'd1);
    queue_reg(REG_END_COLUMN, 64'd5);
    write_regs();
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h42, 1'b0, 1'b0);
    send_item(8'hE1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7A, 1'b0, 1'b0);
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h42, 1'b0, 1'b0);
    send_item(8'hE1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    // empty range: exact match in the text still reports not found
    queue_reg(REG_FOLD, 64'h0);
    queue_reg(REG_START_LINE, 64'd0);
    queue_reg(REG_START_COLUMN, 64'd0);
    queue_reg(REG_END_LINE, 64'd0);
    queue_reg(REG_END_COLUMN, 64'd0);
    write_regs();
    send_item(8'h41, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'hE1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // full range, no folding: wrong case is skipped, exact copy hits
    queue_reg(REG_END_LINE, 64'hFFFF);
    queue_reg(REG_END_COLUMN, 64'hFFF);
    write_regs();
    send_item(8'h61, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'hE1, 1'b0, 1'b0);
    send_item(8'h41, 1'b0, 1'b0);
    send_item(8'h62, 1'b0, 1'b0);
    send_item(8'hE1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    base  = items_sent;
    phase = 0;
    while (items_sent - base < 1950) begin
      wait_idle();
      quiet = (items_sent - base > 1700);
      if (phase < 2) begin
        // longest needle; the second pass writes an oversized length
        for (int i = 0; i < 8; i++) begin
          lo[8*i +: 8] = letter();
          hi[8*i +: 8] = letter();
        end
        queue_reg(REG_NEEDLE_LOW, lo);
        queue_reg(REG_NEEDLE_HIGH, hi);
        queue_reg(REG_NEEDLE_LEN, phase == 0 ? 64'd16 : 64'hFFFF_FFFF_FFFF_FFFF);
        queue_reg(REG_FOLD, phase == 0 ? 64'd1 : 64'd0);
        queue_reg(REG_START_LINE, 64'd0);
        queue_reg(REG_START_COLUMN, 64'd0);
        queue_reg(REG_END_LINE, 64'hFFFF);
        queue_reg(REG_END_COLUMN, 64'hFFF);
        write_regs();
      end else begin
        random_settings();
      end
      if (phase == 5) begin
        // every item here yields a result while the receiver holds off
        gap_pct  = 0;
        hold_req = 1'b1;
        repeat (40) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
      for (int d = 0; d < 4; d++) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        send_document($urandom_range(1, 4), 20);
      end
      phase++;
    end

    wait_idle();
    if (matcher.errors == 0)
      $display("ranged_folding_substring_search_core verification clean");
    else
      $display("ranged_folding_substring_search_core verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rfss_pkg.sv
sv/ranged_folding_substring_search_core.sv
sv/rfss_checker.sv
tb/testbench.sv
